[design/ccm_pkg.sv]
// ---------------------------------------------------------------------------
// ccm_pkg
// Widths, types and register codes shared by the color correction matrix
// block and its channel interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

   localparam int PIXEL_WIDTH    = 16;
   localparam int COEF_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 12;
   localparam int NUM_CHANNELS   = 3;
   localparam int ROW_WIDTH      = COEF_WIDTH * NUM_CHANNELS;
   localparam int DEPTH_WIDTH    = 5;
   localparam int CSR_IDX_WIDTH  = 2;

   // pixel zero-extended to signed, times signed coefficient
   localparam int PROD_WIDTH  = PIXEL_WIDTH + 1 + COEF_WIDTH;
   // three products plus rounding offset
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int SHIFT_WIDTH = SUM_WIDTH - COEF_FRAC_BITS;
   localparam int MAX_WIDTH   = PIXEL_WIDTH + 1;

   localparam int ROUND_OFFSET = 1 << (COEF_FRAC_BITS - 1);

   typedef logic [PIXEL_WIDTH-1:0]       pixel_type;
   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic [ROW_WIDTH-1:0]         row_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic [DEPTH_WIDTH-1:0]       depth_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ROW_RED   = 2'd0,
      CSR_ROW_GREEN = 2'd1,
      CSR_ROW_BLUE  = 2'd2,
      CSR_PIX_BITS  = 2'd3
   } csr_index_type;

   localparam row_type   ROW_RED_RESET   = row_type'(48'h0000_0000_1000);
   localparam row_type   ROW_GREEN_RESET = row_type'(48'h0000_1000_0000);
   localparam row_type   ROW_BLUE_RESET  = row_type'(48'h1000_0000_0000);
   localparam depth_type PIX_BITS_RESET  = depth_type'(14);

endpackage

`default_nettype wire

[design/ccm_if.sv]
// ---------------------------------------------------------------------------
// ccm channel interfaces
// Valid/ready channels for input pixels, corrected pixels and register
// writes of the color correction matrix block.
// ---------------------------------------------------------------------------
`default_nettype none

interface ccm_req_if;
   logic               valid;
   logic               ready;
   ccm_pkg::pixel_type red_in;
   ccm_pkg::pixel_type green_in;
   ccm_pkg::pixel_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface ccm_rsp_if;
   logic               valid;
   logic               ready;
   ccm_pkg::pixel_type red_out;
   ccm_pkg::pixel_type green_out;
   ccm_pkg::pixel_type blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

interface ccm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ccm_pkg::CSR_IDX_WIDTH-1:0]   index;
   ccm_pkg::row_type                    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/color_correction_matrix_3x3.sv]
// ---------------------------------------------------------------------------
// color_correction_matrix_3x3
// 3x3 signed Q3.12 matrix applied to one RGB pixel per beat, with rounding
// and saturation to a programmable bit depth.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus  : input pixel beats (red_in, green_in, blue_in), valid/ready.
//   rsp_bus  : corrected pixel beats (red_out, green_out, blue_out).
//   csr_bus  : register writes, index 0..2 = matrix rows red/green/blue
//              (16-bit coefficient per input channel, red in the low bits),
//              index 3 = pixel_bits. Always ready. Write only while idle.
//   Pipeline : rsp valid rises once the accepted req beat has passed the
//              four register stages, the input register included.
//   Rate     : one pixel per cycle sustained while rsp_bus.ready is high; set
//              by the four-stage register / multiply / sum / saturate pipeline.
//   Reset    : synchronous; pipeline emptied, identity matrix, depth 14.
//   Stall    : when rsp_bus.ready is low the output beat holds; upstream
//              stages keep filling bubbles, and req_bus.ready drops only
//              once every stage holds a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module color_correction_matrix_3x3 (
   input  wire        clock,
   input  wire        reset,
   ccm_req_if.sink    req_bus,
   ccm_rsp_if.source  rsp_bus,
   ccm_csr_if.sink    csr_bus
);

   localparam int NC = ccm_pkg::NUM_CHANNELS;

   // ---------------- configuration registers ----------------
   ccm_pkg::row_type   coef_row_ff [NC];
   ccm_pkg::depth_type pix_bits_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_row_ff[0] <= ccm_pkg::ROW_RED_RESET;
         coef_row_ff[1] <= ccm_pkg::ROW_GREEN_RESET;
         coef_row_ff[2] <= ccm_pkg::ROW_BLUE_RESET;
         pix_bits_ff    <= ccm_pkg::PIX_BITS_RESET;
      end else if (csr_bus.valid) begin
         unique case (ccm_pkg::csr_index_type'(csr_bus.index))
            ccm_pkg::CSR_ROW_RED:   coef_row_ff[0] <= csr_bus.data;
            ccm_pkg::CSR_ROW_GREEN: coef_row_ff[1] <= csr_bus.data;
            ccm_pkg::CSR_ROW_BLUE:  coef_row_ff[2] <= csr_bus.data;
            ccm_pkg::CSR_PIX_BITS:
               pix_bits_ff <= csr_bus.data[ccm_pkg::DEPTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp value: 2^min(pixel_bits, PIXEL_WIDTH) - 1
   ccm_pkg::depth_type          depth;
   logic [ccm_pkg::MAX_WIDTH-1:0] max_val;

   always_comb begin
      if (pix_bits_ff > ccm_pkg::depth_type'(ccm_pkg::PIXEL_WIDTH)) begin
         depth = ccm_pkg::depth_type'(ccm_pkg::PIXEL_WIDTH);
      end else begin
         depth = pix_bits_ff;
      end
      max_val = (ccm_pkg::MAX_WIDTH'(1) << depth) - ccm_pkg::MAX_WIDTH'(1);
   end

   // ---------------- pipeline flow control ----------------
   // Each stage loads when it is empty or the next stage is moving.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !v4_ff || rsp_bus.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_bus.ready = adv1;

   assign v1_in = adv1 ? req_bus.valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   ccm_pkg::pixel_type pix_ff [NC];

   always_ff @(posedge clock) begin
      if (adv1) begin
         pix_ff[0] <= req_bus.red_in;
         pix_ff[1] <= req_bus.green_in;
         pix_ff[2] <= req_bus.blue_in;
      end
   end

   // ---------------- stage 2: nine products ----------------
   // prod_ff[row][k] = pixel k * coefficient k of output row
   ccm_pkg::prod_type prod_ff [NC][NC];
   ccm_pkg::prod_type prod_in [NC][NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         for (int k = 0; k < NC; k++) begin
            prod_in[r][k] =
               $signed({1'b0, pix_ff[k]}) *
               ccm_pkg::coef_type'(coef_row_ff[r][k*ccm_pkg::COEF_WIDTH +:
                                                  ccm_pkg::COEF_WIDTH]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------- stage 3: dot product plus half LSB ----------------
   ccm_pkg::sum_type sum_ff [NC];
   ccm_pkg::sum_type sum_in [NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         sum_in[r] = ccm_pkg::SUM_WIDTH'(prod_ff[r][0])
                   + ccm_pkg::SUM_WIDTH'(prod_ff[r][1])
                   + ccm_pkg::SUM_WIDTH'(prod_ff[r][2])
                   + ccm_pkg::sum_type'(ccm_pkg::ROUND_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------- stage 4: shift and saturate ----------------
   ccm_pkg::pixel_type out_ff [NC];
   ccm_pkg::pixel_type out_in [NC];
   logic [ccm_pkg::SHIFT_WIDTH-1:0] shifted [NC];

   always_comb begin
      for (int r = 0; r < NC; r++) begin
         shifted[r] = sum_ff[r][ccm_pkg::SUM_WIDTH-1:ccm_pkg::COEF_FRAC_BITS];
         if (sum_ff[r][ccm_pkg::SUM_WIDTH-1]) begin
            out_in[r] = '0;  // negative after rounding
         end else if (shifted[r] > ccm_pkg::SHIFT_WIDTH'(max_val)) begin
            out_in[r] = max_val[ccm_pkg::PIXEL_WIDTH-1:0];
         end else begin
            out_in[r] = shifted[r][ccm_pkg::PIXEL_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid     = v4_ff;
   assign rsp_bus.red_out   = out_ff[0];
   assign rsp_bus.green_out = out_ff[1];
   assign rsp_bus.blue_out  = out_ff[2];

endmodule

`default_nettype wire
